// ===== rtl/pst_pkg.sv =====
// Shared types, token codes, character constants and keyword table of the tokenizer.
package pst_pkg;

   localparam int MAX_WORD_CHARS_DEF = 11;
   localparam int TEXT_MAX           = 11;
   localparam int RSP_QUEUE_DEPTH    = 4;
   localparam int KW_COUNT           = 10;
   localparam int KW_MAX_LEN         = 8;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_COLON   = 3'd1,
      MODE_PAREN   = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_STAR    = 3'd4
   } scan_mode_type;

   localparam logic [4:0] TK_NONE    = 5'd0;
   localparam logic [4:0] TK_ENDDOT  = 5'd5;
   localparam logic [4:0] TK_SEMIC   = 5'd12;
   localparam logic [4:0] TK_COLON   = 5'd13;
   localparam logic [4:0] TK_COMMA   = 5'd14;
   localparam logic [4:0] TK_COLONEQ = 5'd15;
   localparam logic [4:0] TK_ADD     = 5'd16;
   localparam logic [4:0] TK_SUBT    = 5'd17;
   localparam logic [4:0] TK_MULT    = 5'd18;
   localparam logic [4:0] TK_LPAREN  = 5'd20;
   localparam logic [4:0] TK_RPAREN  = 5'd21;
   localparam logic [4:0] TK_ID      = 5'd22;
   localparam logic [4:0] TK_INT     = 5'd23;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_INVALID = 2'd1;
   localparam logic [1:0] ERR_TRUNC   = 2'd2;

   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = "\t";
   localparam logic [7:0] CH_LF     = "\n";
   localparam logic [7:0] CH_COLON  = ":";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SEMIC  = ";";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_UA     = "A";
   localparam logic [7:0] CH_UZ     = "Z";
   localparam logic [7:0] CH_LA     = "a";
   localparam logic [7:0] CH_LZ     = "z";
   localparam logic [7:0] CASE_GAP  = 8'd32;

   // Keywords spelt backwards so that the first character lands in the low byte.
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("MARGORP"), 64'("RAV"), 64'("NIGEB"), 64'("DNE"), 64'("REGETNI"),
      64'("ROF"), 64'("DAER"), 64'("ETIRW"), 64'("OT"), 64'("OD")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd7, 4'd3, 4'd5, 4'd3, 4'd7, 4'd3, 4'd4, 4'd5, 4'd2, 4'd2
   };
   localparam logic [4:0] KW_CODE [KW_COUNT] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11
   };

   typedef struct packed {
      logic [4:0]  token_type;
      logic [63:0] text_first;
      logic [23:0] text_rest;
      logic [3:0]  text_length;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    nonempty;
      rsp_type res;
   } word_info_type;

   typedef struct packed {
      logic       append;
      logic       clear;
      logic [7:0] upper;
   } word_ctl_type;

   function automatic rsp_type one_char_res(logic [4:0] code, logic [7:0] ch,
                                            logic [1:0] err);
      rsp_type r;
      r.token_type  = code;
      r.text_first  = {56'h0, ch};
      r.text_rest   = 24'h0;
      r.text_length = 4'd1;
      r.error_code  = err;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/pst_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
interface pst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface pst_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_type;
   logic [63:0] text_first;
   logic [23:0] text_rest;
   logic [3:0]  text_length;
   logic [1:0]  error_code;
   logic        last;

   modport source (output valid, output token_type, output text_first, output text_rest,
                   output text_length, output error_code, output last, input ready);
   modport sink   (input valid, input token_type, input text_first, input text_rest,
                   input text_length, input error_code, input last, output ready);
endinterface

// ===== rtl/pst_word.sv =====
// Word buffer: collects upper-cased characters and classifies the finished word.
module pst_word #(
   parameter int MaxChars = pst_pkg::MAX_WORD_CHARS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pst_pkg::word_ctl_type  ctl,
   output pst_pkg::word_info_type info
);
   import pst_pkg::*;

   localparam int LenW = $clog2(MaxChars + 1);
   localparam int IdxW = $clog2(MaxChars);

   logic [7:0]      word_ff [MaxChars];
   logic [LenW-1:0] len_ff, len_in;
   logic            ovf_ff, ovf_in;
   logic [4:0]      len5;
   logic [7:0]      tb  [TEXT_MAX];
   logic [7:0]      win [KW_MAX_LEN];
   logic [MaxChars-1:0] dig_ok;
   logic [4:0]      kw_code;

   // Character store: no reset, only entries below the length affect the outputs.
   always_ff @(posedge clock) begin
      if (ctl.append && (len_ff < LenW'(MaxChars))) begin
         word_ff[len_ff[IdxW-1:0]] <= ctl.upper;
      end
   end

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (ctl.clear) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (ctl.append) begin
         if (len_ff < LenW'(MaxChars)) len_in = len_ff + LenW'(1);
         else                          ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   assign len5 = 5'(len_ff);

   for (genvar i = 0; i < TEXT_MAX; i++) begin : g_text
      if (i < MaxChars) begin : g_have
         assign tb[i] = (LenW'(i) < len_ff) ? word_ff[i] : 8'h00;
      end else begin : g_none
         assign tb[i] = 8'h00;
      end
   end

   for (genvar j = 0; j < KW_MAX_LEN; j++) begin : g_win
      if (j < MaxChars) begin : g_have
         assign win[j] = word_ff[j];
      end else begin : g_none
         assign win[j] = 8'h00;
      end
   end

   for (genvar i = 0; i < MaxChars; i++) begin : g_dig
      assign dig_ok[i] = (LenW'(i) >= len_ff) ||
                         ((word_ff[i] >= CH_ZERO) && (word_ff[i] <= CH_NINE));
   end

   always_comb begin
      logic hit;
      kw_code = TK_ID;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (len5 == 5'(KW_LEN[k]));
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if ((j < int'(KW_LEN[k])) && (win[j] != KW_TEXT[k][8*j +: 8])) hit = 1'b0;
         end
         if (hit) kw_code = KW_CODE[k];
      end
   end

   always_comb begin
      info.nonempty       = (len_ff != '0);
      info.res.token_type = (&dig_ok) ? TK_INT : kw_code;
      for (int i = 0; i < 8; i++) info.res.text_first[8*i +: 8] = tb[i];
      for (int i = 0; i < 3; i++) info.res.text_rest[8*i +: 8] = tb[8 + i];
      info.res.text_length = (len5 > 5'(TEXT_MAX)) ? 4'(TEXT_MAX) : len5[3:0];
      info.res.error_code  = ovf_ff ? ERR_TRUNC : ERR_NONE;
      info.res.last        = 1'b0;
   end

`ifndef SYNTHESIS
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LenW'(MaxChars)))
      else $error("word overflow flagged while buffer not full");
`endif

endmodule

// ===== rtl/pst_scan.sv =====
// Scan-mode state machine and per-byte token decision.
module pst_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             char_in,
   input  pst_pkg::word_info_type word,
   output pst_pkg::word_ctl_type  word_ctl,
   output pst_pkg::rsp_type       res0,
   output pst_pkg::rsp_type       res1,
   output logic [1:0]             push_n
);
   import pst_pkg::*;

   scan_mode_type mode_ff, mode_in, mode_nx;
   logic    normal, alnum, lower;
   logic    pend_v, word_v, sym_v, v0, v1;
   rsp_type pend, sym;

   assign lower = (char_in >= CH_LA) && (char_in <= CH_LZ);
   assign alnum = lower || ((char_in >= CH_UA) && (char_in <= CH_UZ)) ||
                  ((char_in >= CH_ZERO) && (char_in <= CH_NINE));

   always_comb begin
      mode_nx = mode_ff;
      normal  = 1'b0;
      pend_v  = 1'b0;
      pend    = one_char_res(TK_COLON, CH_COLON, ERR_NONE);
      word_v  = 1'b0;
      sym_v   = 1'b0;
      sym     = one_char_res(TK_NONE, char_in, ERR_INVALID);
      word_ctl.append = 1'b0;
      word_ctl.clear  = 1'b0;
      word_ctl.upper  = lower ? (char_in - CASE_GAP) : char_in;

      case (mode_ff)
         MODE_COMMENT: begin
            if (char_in == CH_STAR) mode_nx = MODE_STAR;
         end
         MODE_STAR: begin
            if (char_in == CH_RPAREN)    mode_nx = MODE_NORMAL;
            else if (char_in != CH_STAR) mode_nx = MODE_COMMENT;
         end
         MODE_COLON: begin
            mode_nx = MODE_NORMAL;
            if (char_in == CH_EQUAL) begin
               sym_v = 1'b1;
               sym   = one_char_res(TK_COLONEQ, CH_COLON, ERR_NONE);
               sym.text_first  = {48'h0, CH_EQUAL, CH_COLON};
               sym.text_length = 4'd2;
            end else begin
               pend_v = 1'b1;
               normal = 1'b1;
            end
         end
         MODE_PAREN: begin
            mode_nx = MODE_NORMAL;
            if (char_in == CH_STAR) begin
               mode_nx = MODE_COMMENT;
            end else begin
               pend_v = 1'b1;
               pend   = one_char_res(TK_LPAREN, CH_LPAREN, ERR_NONE);
               normal = 1'b1;
            end
         end
         default: begin
            mode_nx = MODE_NORMAL;
            normal  = 1'b1;
         end
      endcase

      if (normal) begin
         if (alnum) begin
            word_ctl.append = 1'b1;
         end else begin
            // drop a word that runs straight into a dot
            word_v = word.nonempty && (char_in != CH_DOT);
            word_ctl.clear = 1'b1;
            case (char_in)
               CH_SPACE, CH_TAB, CH_LF: ;
               CH_COLON:  mode_nx = MODE_COLON;
               CH_LPAREN: mode_nx = MODE_PAREN;
               CH_SEMIC: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_SEMIC, char_in, ERR_NONE);
               end
               CH_COMMA: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_COMMA, char_in, ERR_NONE);
               end
               CH_PLUS: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_ADD, char_in, ERR_NONE);
               end
               CH_MINUS: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_SUBT, char_in, ERR_NONE);
               end
               CH_STAR: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_MULT, char_in, ERR_NONE);
               end
               CH_RPAREN: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_RPAREN, char_in, ERR_NONE);
               end
               CH_DOT: begin
                  sym_v = 1'b1;
                  sym   = one_char_res(TK_ENDDOT, char_in, ERR_NONE);
               end
               default: sym_v = 1'b1;
            endcase
         end
      end

      word_ctl.append = word_ctl.append && fire;
      word_ctl.clear  = word_ctl.clear && fire;
      mode_in = fire ? mode_nx : mode_ff;

      // order: pending symbol, word, symbol; at most two are ever present
      v0   = pend_v || word_v || sym_v;
      v1   = pend_v ? (word_v || sym_v) : (word_v && sym_v);
      res0 = pend_v ? pend : (word_v ? word.res : sym);
      res1 = (pend_v && word_v) ? word.res : sym;
      res0.last = !v1;
      res1.last = 1'b1;
      push_n = fire ? (2'(v0) + 2'(v1)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_NORMAL;
      else       mode_ff <= mode_in;
   end

endmodule

// ===== rtl/pst_rsp_fifo.sv =====
// Small token queue that takes up to two tokens a cycle and delivers one.
module pst_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  pst_pkg::rsp_type  d0,
   input  pst_pkg::rsp_type  d1,
   output logic              room2,
   pst_rsp_if.source         rsp_bus
);
   import pst_pkg::*;

   localparam int PtrW = $clog2(RSP_QUEUE_DEPTH);
   localparam int CntW = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_type         mem [RSP_QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            pop;
   rsp_type         head;

   assign pop   = rsp_bus.valid && rsp_bus.ready;
   assign room2 = (cnt_ff <= CntW'(RSP_QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem[wr_ff] <= d0;
      if (push_n == 2'd2) mem[wr_ff + PtrW'(1)] <= d1;
   end

   always_comb begin
      wr_in  = wr_ff + PtrW'(push_n);
      rd_in  = rd_ff + PtrW'(pop);
      cnt_in = cnt_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head                = mem[rd_ff];
   assign rsp_bus.valid       = (cnt_ff != '0);
   assign rsp_bus.token_type  = head.token_type;
   assign rsp_bus.text_first  = head.text_first;
   assign rsp_bus.text_rest   = head.text_rest;
   assign rsp_bus.text_length = head.text_length;
   assign rsp_bus.error_code  = head.error_code;
   assign rsp_bus.last        = head.last;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> room2)
      else $error("token queue written without room for two entries");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(RSP_QUEUE_DEPTH))
      else $error("token queue count beyond depth");
`endif

endmodule

// ===== rtl/pascal_subset_tokenizer.sv =====
// Pascal subset tokenizer top level: input register, scanner, word buffer, token queue.
//
// Takes source bytes on req_bus and returns tokens on rsp_bus, both valid/ready channels.
// Letters (folded to upper case) and digits build a word of up to MAX_WORD_CHARS
// characters; whitespace, a symbol or any other byte ends it, and it comes out as a
// keyword, INT or ID token, flagged as truncated when characters were dropped. ':=' and
// '(*' are recognised by holding ':' or '(' for one byte; a comment is skipped up to the
// first '*)' that follows its opener. A word directly before '.' is dropped. Bytes outside
// the character set give an error-only token. There is no flush: a word or a held ':' or
// '(' is emitted only when a later byte arrives. Each byte transfer yields zero, one or two
// token transfers, the final one marked by last. Rate: one byte per cycle while each byte
// yields at most one token and rsp_bus takes tokens as they come; a byte yielding two
// tokens is absorbed by the four-entry token queue, and req_bus.ready drops only while
// that queue has fewer than two free entries. The byte sits in the input register while
// the scanner writes its tokens into the token queue, and rsp_bus is driven from that
// queue's registers.
// No clearing pass after reset.
module pascal_subset_tokenizer #(
   parameter int MAX_WORD_CHARS = pst_pkg::MAX_WORD_CHARS_DEF
) (
   input logic       clock,
   input logic       reset,
   pst_req_if.sink   req_bus,
   pst_rsp_if.source rsp_bus
);
   import pst_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    char_ff, char_in_d;
   logic          room2, advance;
   word_ctl_type  word_ctl;
   word_info_type word_info;
   rsp_type       res0, res1;
   logic [1:0]    push_n;

   // Advance the held byte once the queue can take both of its possible tokens.
   assign advance       = in_valid_ff && room2;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in_d   = char_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         char_in_d   = req_bus.char_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Payload register: no reset, qualified by in_valid_ff.
   always_ff @(posedge clock) begin
      char_ff <= char_in_d;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   // Decide the tokens for the held byte and update the scan mode.
   pst_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .char_in  (char_ff),
      .word     (word_info),
      .word_ctl (word_ctl),
      .res0     (res0),
      .res1     (res1),
      .push_n   (push_n)
   );

   // Hold the word being built and classify it.
   pst_word #(
      .MaxChars (MAX_WORD_CHARS)
   ) u_word (
      .clock (clock),
      .reset (reset),
      .ctl   (word_ctl),
      .info  (word_info)
   );

   // Queue tokens towards rsp_bus.
   pst_rsp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_n  (push_n),
      .d0      (res0),
      .d1      (res1),
      .room2   (room2),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(char_ff)))
      else $error("held byte lost or changed while stalled");
`endif

endmodule
